[hw/rtl/assert_macros.svh]
// Assertion helper macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hw/rtl/ibds_pkg.sv]
// Shared types, constants and lookup functions for the image block downscaler.
// No dependencies; used by all ibds modules and the top level.
package ibds_pkg;

    localparam int PIX_W       = 8;
    localparam int SUM_W       = 16;
    localparam int ADD_W       = PIX_W + 3;
    localparam int DIM_W       = 15;
    localparam int POS_W       = 14;
    localparam int SUB_W       = 4;
    localparam int FACTOR_W    = 5;
    localparam int RECIP_W     = 23;
    localparam int RECIP_SHIFT = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 15;

    localparam logic [FACTOR_W-1:0] MAX_FACTOR = 5'd16;
    localparam logic [FACTOR_W-1:0] GAUSS_FACTOR = 5'd3;
    localparam logic [DIM_W-1:0]    DIM_MAX    = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FACTOR     = 2'd0,
        CFG_COLOR_MODE = 2'd1,
        CFG_IN_WIDTH   = 2'd2,
        CFG_IN_HEIGHT  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] pix_red;
        logic [PIX_W-1:0] pix_green;
        logic [PIX_W-1:0] pix_blue;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_red;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_blue;
        logic             row_end;
        logic             frame_end;
    } res_t;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } sums_t;

    // Per-pixel control from the position sequencer to the accumulator.
    typedef struct packed {
        logic       active;     // block lies inside the output image
        logic       first;      // top-left pixel of its block
        logic       last;       // bottom-right pixel of its block
        logic       row_end;
        logic       frame_end;
        logic [2:0] weight;
    } ctl_t;

    localparam logic [2:0] GAUSS_W [3][3] = '{
        '{3'd1, 3'd2, 3'd1},
        '{3'd2, 3'd4, 3'd2},
        '{3'd1, 3'd2, 3'd1}
    };

    function automatic logic [FACTOR_W-1:0] clamp_factor(input logic [FACTOR_W-1:0] f);
        logic [FACTOR_W-1:0] r;
        r = f;
        if (f == '0) r = 5'd1;
        else if (f > MAX_FACTOR) r = MAX_FACTOR;
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) r = 15'd1;
        else if (d > DIM_MAX) r = DIM_MAX;
        return r;
    endfunction

    function automatic logic [2:0] gauss_weight(input logic [1:0] r, input logic [1:0] c);
        logic [2:0] w;
        w = 3'd1;
        if (r < 2'd3 && c < 2'd3) w = GAUSS_W[r][c];
        return w;
    endfunction

    // ceil(2^24 / divisor); exact for 16-bit sums and divisors up to 256.
    // Odd factors other than 3 map to zero, which zeroes the result.
    function automatic logic [RECIP_W-1:0] scale_recip(input logic [FACTOR_W-1:0] f);
        logic [RECIP_W-1:0] m;
        case (f)
            5'd2:    m = 23'd4194304;
            5'd3:    m = 23'd1048576;   // gaussian kernel, divide by 16
            5'd4:    m = 23'd1048576;
            5'd6:    m = 23'd466034;
            5'd8:    m = 23'd262144;
            5'd10:   m = 23'd167773;
            5'd12:   m = 23'd116509;
            5'd14:   m = 23'd85599;
            5'd16:   m = 23'd65536;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

[hw/rtl/image_block_downscaler.sv]
// Image block downscaler, top level: configuration registers, sequencer,
// column-sum RAM and scaling stage. Depends on ibds_pkg and the ibds modules.
//
// Pixels arrive in raster order, one request per pixel, and the image shrinks
// by the configured factor. Each output pixel is the sum of one factor-by-
// factor block (or the 1-2-1 gaussian weighting for factor 3), kept per output
// column in one RAM of MAX_OUT_WIDTH x 48 bits (three 16-bit channel sums).
// Every pixel does a read-modify-write of its column entry; the read is issued
// at acceptance and the write comes from the s1 registers when enabled, with a
// forward path covering back-to-back pixels of the same column, so the block
// takes one pixel per clock unless stalled. The RAM loop sets that figure. A
// result leaves on the block's bottom-right pixel via the s1, s2 and output
// registers, and a reciprocal multiply replaces the divide. The first pixel of
// each block ignores what the RAM holds, so neither reset nor a configuration
// write needs a clearing pass. While a result is held in the output register
// under stall the whole pipeline waits and pix_stall is raised. Any
// configuration write restarts the frame; write only while the block is idle.
module image_block_downscaler #(
    parameter int MAX_OUT_WIDTH = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [ibds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ibds_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            pix_valid,
    output logic                            pix_stall,
    input  ibds_pkg::pix_t                  pix,
    output logic                            res_valid,
    input  logic                            res_stall,
    output ibds_pkg::res_t                  res
);

    localparam int AW = $clog2(MAX_OUT_WIDTH);

    // configuration registers
    logic [ibds_pkg::FACTOR_W-1:0] factor_reg;
    logic                          color_mode_reg;
    logic [ibds_pkg::DIM_W-1:0]    in_width_reg;
    logic [ibds_pkg::DIM_W-1:0]    in_height_reg;

    logic [ibds_pkg::FACTOR_W-1:0] factor_c;
    logic [ibds_pkg::DIM_W-1:0]    width_c, height_c;
    logic [ibds_pkg::RECIP_W-1:0]  recip;

    logic            en, take;
    ibds_pkg::pix_t  pix_m;
    ibds_pkg::ctl_t  seq_ctl;
    logic [AW-1:0]   seq_addr;
    logic            acc_valid;
    ibds_pkg::sums_t acc_sums;
    ibds_pkg::ctl_t  acc_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg     <= 5'd2;
            color_mode_reg <= 1'b1;
            in_width_reg   <= 15'd640;
            in_height_reg  <= 15'd480;
        end
        else if (cfg_write)
        begin
            unique case (ibds_pkg::cfg_idx_t'(cfg_index))
                ibds_pkg::CFG_FACTOR:     factor_reg     <= cfg_data[ibds_pkg::FACTOR_W-1:0];
                ibds_pkg::CFG_COLOR_MODE: color_mode_reg <= cfg_data[0];
                ibds_pkg::CFG_IN_WIDTH:   in_width_reg   <= cfg_data;
                ibds_pkg::CFG_IN_HEIGHT:  in_height_reg  <= cfg_data;
                default:                  factor_reg     <= factor_reg;
            endcase
        end
    end

    assign factor_c = ibds_pkg::clamp_factor(factor_reg);
    assign width_c  = ibds_pkg::clamp_dim(in_width_reg);
    assign height_c = ibds_pkg::clamp_dim(in_height_reg);
    assign recip    = ibds_pkg::scale_recip(factor_c);

    // whole pipeline advances unless a finished result is held under stall
    assign en        = !res_valid || !res_stall;
    assign pix_stall = !en;
    assign take      = pix_valid && en;

    // grayscale: green and blue never enter the sums
    always_comb
    begin
        pix_m.pix_red   = pix.pix_red;
        pix_m.pix_green = color_mode_reg ? pix.pix_green : '0;
        pix_m.pix_blue  = color_mode_reg ? pix.pix_blue  : '0;
    end

    ibds_seq #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .AW            (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write),
        .step    (take),
        .factor  (factor_c),
        .width   (width_c),
        .height  (height_c),
        .ctl     (seq_ctl),
        .addr    (seq_addr)
    );

    ibds_colmem #(
        .DEPTH (MAX_OUT_WIDTH),
        .AW    (AW)
    ) u_colmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .take       (take),
        .addr       (seq_addr),
        .pix        (pix_m),
        .ctl        (seq_ctl),
        .done_valid (acc_valid),
        .done_sums  (acc_sums),
        .done_ctl   (acc_ctl)
    );

    ibds_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (acc_valid),
        .sums      (acc_sums),
        .ctl       (acc_ctl),
        .recip     (recip),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

[hw/rtl/ibds_seq.sv]
// Position sequencer: raster, block and sub-block counters for the downscaler.
// Depends on ibds_pkg.
module ibds_seq #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int AW            = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          restart,
    input  logic                          step,
    input  logic [ibds_pkg::FACTOR_W-1:0] factor,
    input  logic [ibds_pkg::DIM_W-1:0]    width,
    input  logic [ibds_pkg::DIM_W-1:0]    height,
    output ibds_pkg::ctl_t                ctl,
    output logic [AW-1:0]                 addr
);

    localparam int PW = ibds_pkg::POS_W;
    localparam int SW = ibds_pkg::SUB_W;
    localparam int FW = ibds_pkg::FACTOR_W;
    localparam int DW = ibds_pkg::DIM_W;
    localparam logic [PW:0] OUT_LIMIT = (PW+1)'(MAX_OUT_WIDTH);

    logic [PW-1:0] col_pos_reg, col_pos_next;
    logic [PW-1:0] row_pos_reg, row_pos_next;
    logic [PW-1:0] blk_col_reg, blk_col_next;
    logic [PW-1:0] col_base_reg, col_base_next;
    logic [PW-1:0] row_base_reg, row_base_next;
    logic [SW-1:0] sub_col_reg, sub_col_next;
    logic [SW-1:0] sub_row_reg, sub_row_next;

    logic col_last, row_last, sub_col_wrap, sub_row_wrap;
    logic col_fit, row_fit, col_more, row_more, col_in_range;

    assign col_last     = (DW'(col_pos_reg) + 1'b1) >= width;
    assign row_last     = (DW'(row_pos_reg) + 1'b1) >= height;
    assign sub_col_wrap = (FW'(sub_col_reg) + 1'b1) >= factor;
    assign sub_row_wrap = (FW'(sub_row_reg) + 1'b1) >= factor;

    // block fits when its start plus the factor stays within the image
    assign col_fit  = ((DW+1)'(col_base_reg) + (DW+1)'(factor)) <= (DW+1)'(width);
    assign row_fit  = ((DW+1)'(row_base_reg) + (DW+1)'(factor)) <= (DW+1)'(height);
    assign col_more = ((DW+1)'(col_base_reg) + (DW+1)'({factor, 1'b0})) <= (DW+1)'(width);
    assign row_more = ((DW+1)'(row_base_reg) + (DW+1)'({factor, 1'b0})) <= (DW+1)'(height);
    assign col_in_range = {1'b0, blk_col_reg} < OUT_LIMIT;

    always_comb
    begin
        ctl.active    = col_fit && row_fit && col_in_range;
        ctl.first     = (sub_row_reg == '0) && (sub_col_reg == '0);
        ctl.last      = ((FW'(sub_row_reg) + 1'b1) == factor)
                     && ((FW'(sub_col_reg) + 1'b1) == factor);
        ctl.row_end   = !col_more || ({1'b0, blk_col_reg} == OUT_LIMIT - 1'b1);
        ctl.frame_end = ctl.row_end && !row_more;
        ctl.weight    = (factor == ibds_pkg::GAUSS_FACTOR)
                      ? ibds_pkg::gauss_weight(sub_row_reg[1:0], sub_col_reg[1:0])
                      : 3'd1;
    end

    assign addr = blk_col_reg[AW-1:0];

    always_comb
    begin
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        blk_col_next  = blk_col_reg;
        col_base_next = col_base_reg;
        row_base_next = row_base_reg;
        sub_col_next  = sub_col_reg;
        sub_row_next  = sub_row_reg;
        if (restart)
        begin
            col_pos_next  = '0;
            row_pos_next  = '0;
            blk_col_next  = '0;
            col_base_next = '0;
            row_base_next = '0;
            sub_col_next  = '0;
            sub_row_next  = '0;
        end
        else if (step)
        begin
            if (col_last)
            begin
                col_pos_next  = '0;
                sub_col_next  = '0;
                blk_col_next  = '0;
                col_base_next = '0;
                if (row_last)
                begin
                    row_pos_next  = '0;
                    sub_row_next  = '0;
                    row_base_next = '0;
                end
                else
                begin
                    row_pos_next = row_pos_reg + 1'b1;
                    if (sub_row_wrap)
                    begin
                        sub_row_next  = '0;
                        row_base_next = row_base_reg + PW'(factor);
                    end
                    else
                    begin
                        sub_row_next = sub_row_reg + 1'b1;
                    end
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + 1'b1;
                if (sub_col_wrap)
                begin
                    sub_col_next  = '0;
                    blk_col_next  = blk_col_reg + 1'b1;
                    col_base_next = col_base_reg + PW'(factor);
                end
                else
                begin
                    sub_col_next = sub_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            blk_col_reg  <= '0;
            col_base_reg <= '0;
            row_base_reg <= '0;
            sub_col_reg  <= '0;
            sub_row_reg  <= '0;
        end
        else
        begin
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            blk_col_reg  <= blk_col_next;
            col_base_reg <= col_base_next;
            row_base_reg <= row_base_next;
            sub_col_reg  <= sub_col_next;
            sub_row_reg  <= sub_row_next;
        end
    end

endmodule

[hw/rtl/ibds_colmem.sv]
// Column-sum RAM with read-modify-write stage and write-to-read forwarding.
// Depends on ibds_pkg.
module ibds_colmem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           take,
    input  logic [AW-1:0]  addr,
    input  ibds_pkg::pix_t pix,
    input  ibds_pkg::ctl_t ctl,
    output logic           done_valid,
    output ibds_pkg::sums_t done_sums,
    output ibds_pkg::ctl_t done_ctl
);

    localparam int AD = ibds_pkg::ADD_W;
    localparam int SM = ibds_pkg::SUM_W;

    ibds_pkg::sums_t mem [DEPTH];

    logic            s1_valid_reg;
    logic            fwd_hit_reg;
    ibds_pkg::ctl_t  s1_ctl_reg;
    logic [AW-1:0]   s1_addr_reg;
    logic [AD-1:0]   add_r_reg, add_g_reg, add_b_reg;
    ibds_pkg::sums_t rd_data_reg;
    ibds_pkg::sums_t fwd_data_reg;

    ibds_pkg::sums_t old_sums, new_sums, wr_data;
    logic            wr_en;

    // first pixel of a block starts from zero, so the RAM never needs clearing
    always_comb
    begin
        if (s1_ctl_reg.first) old_sums = '0;
        else if (fwd_hit_reg) old_sums = fwd_data_reg;
        else                  old_sums = rd_data_reg;
        new_sums.red   = old_sums.red   + SM'(add_r_reg);
        new_sums.green = old_sums.green + SM'(add_g_reg);
        new_sums.blue  = old_sums.blue  + SM'(add_b_reg);
    end

    assign wr_en   = en && s1_valid_reg && s1_ctl_reg.active;
    assign wr_data = s1_ctl_reg.last ? '0 : new_sums;

    always_ff @(posedge clk)
    begin
        if (en && take)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[s1_addr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= take;
            if (take)
                fwd_hit_reg <= wr_en && (s1_addr_reg == addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && take)
        begin
            s1_ctl_reg   <= ctl;
            s1_addr_reg  <= addr;
            add_r_reg    <= AD'(pix.pix_red)   * AD'(ctl.weight);
            add_g_reg    <= AD'(pix.pix_green) * AD'(ctl.weight);
            add_b_reg    <= AD'(pix.pix_blue)  * AD'(ctl.weight);
            fwd_data_reg <= wr_data;
        end
    end

    assign done_valid = s1_valid_reg && s1_ctl_reg.active && s1_ctl_reg.last;
    assign done_sums  = new_sums;
    assign done_ctl   = s1_ctl_reg;

endmodule

[hw/rtl/ibds_scale.sv]
// Block-sum scaling: reciprocal multiply per channel and the output register.
// Depends on ibds_pkg.
module ibds_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  ibds_pkg::sums_t              sums,
    input  ibds_pkg::ctl_t               ctl,
    input  logic [ibds_pkg::RECIP_W-1:0] recip,
    output logic                         res_valid,
    output ibds_pkg::res_t               res
);

    localparam int PW = ibds_pkg::SUM_W + ibds_pkg::RECIP_W;
    localparam int SH = ibds_pkg::RECIP_SHIFT;
    localparam int XW = ibds_pkg::PIX_W;

    logic                         s2_valid_reg;
    ibds_pkg::sums_t              s2_sums_reg;
    logic                         s2_row_end_reg, s2_frame_end_reg;
    logic [ibds_pkg::RECIP_W-1:0] s2_recip_reg;
    logic                         res_valid_reg;
    ibds_pkg::res_t               res_reg;

    logic [PW-1:0] prod_r, prod_g, prod_b;

    assign prod_r = PW'(s2_sums_reg.red)   * PW'(s2_recip_reg);
    assign prod_g = PW'(s2_sums_reg.green) * PW'(s2_recip_reg);
    assign prod_b = PW'(s2_sums_reg.blue)  * PW'(s2_recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= in_valid;
            res_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_valid)
        begin
            s2_sums_reg      <= sums;
            s2_row_end_reg   <= ctl.row_end;
            s2_frame_end_reg <= ctl.frame_end;
            s2_recip_reg     <= recip;
        end
        if (en && s2_valid_reg)
        begin
            res_reg.out_red   <= prod_r[SH +: XW];
            res_reg.out_green <= prod_g[SH +: XW];
            res_reg.out_blue  <= prod_b[SH +: XW];
            res_reg.row_end   <= s2_row_end_reg;
            res_reg.frame_end <= s2_frame_end_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

[hw/rtl/ibds_check.sv]
// Port-level checker for the image block downscaler, bound to the top level.
// Depends on ibds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ibds_check (
    input logic           clk,
    input logic           rst_n,
    input logic           pix_valid,
    input logic           pix_stall,
    input logic           res_valid,
    input logic           res_stall,
    input ibds_pkg::res_t res
);

    // a stalled result request stays put
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && res_stall, res_valid && $stable(res))

    // the last pixel of the image also closes its output row
    `ASSERT_NOW(a_frame_row, clk, rst_n, res_valid && res.frame_end, res.row_end)

    // input backpressure only comes from a held result
    `ASSERT_NOW(a_stall_cause, clk, rst_n, pix_stall, res_valid && res_stall)

    // a held result blocks new pixel requests
    `ASSERT_NOW(a_stall_block, clk, rst_n, pix_valid && res_valid && res_stall, pix_stall)

endmodule

bind image_block_downscaler ibds_check u_ibds_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);
